// File: design/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants for the drive stepper and spindle model.
// ----------------------------------------------------------------------------
`default_nettype none

package dss_pkg;

  localparam int FRAC_W  = 18;
  localparam int SPIN_W  = 17;
  localparam int CD_W    = 14;
  localparam int TC_W    = 6;
  localparam int TRK_OUT_W = 6;

  localparam logic [TC_W-1:0]   TRACK_COUNT_RST = 6'd35;
  localparam int                INSERT_TRACK    = 18;
  localparam logic [SPIN_W-1:0] SPIN_FULL       = 17'd65536;
  localparam logic [SPIN_W-1:0] SPIN_STEP       = 17'd4;
  localparam logic [FRAC_W-1:0] FRAC_POS_LIMIT  = 18'h10000;
  localparam logic [FRAC_W-1:0] FRAC_NEG_LIMIT  = 18'h30000;

  typedef enum logic [1:0] {
    DIR_NONE = 2'b00,
    DIR_UP   = 2'b01,
    DIR_DOWN = 2'b11
  } dir_t;

  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_INSERT = 1'b1
  } op_t;

  typedef struct packed {
    logic       op;
    logic [1:0] phase_cmd;
    logic       motor_on;
    logic       write_protect;
  } item_t;

  typedef struct packed {
    logic                 head_ready;
    logic [TRK_OUT_W-1:0] track_number;
    logic                 protect_sense;
    logic [1:0]           motor_phase;
  } result_t;

  // handshake state passed from the input stage to the result stage
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

endpackage

`default_nettype wire

// File: design/dss_channels.sv
// ----------------------------------------------------------------------------
// dss channels
// Valid/ready channels for tick items, result items and the config write.
// ----------------------------------------------------------------------------
`default_nettype none

interface dss_item_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [1:0] phase_cmd;
  logic       motor_on;
  logic       write_protect;

  modport source (output valid, output op, output phase_cmd, output motor_on,
                  output write_protect, input ready);
  modport sink   (input valid, input op, input phase_cmd, input motor_on,
                  input write_protect, output ready);
endinterface

interface dss_result_if;
  logic       valid;
  logic       ready;
  logic       head_ready;
  logic [5:0] track_number;
  logic       protect_sense;
  logic [1:0] motor_phase;

  modport source (output valid, output head_ready, output track_number,
                  output protect_sense, output motor_phase, input ready);
  modport sink   (input valid, input head_ready, input track_number,
                  input protect_sense, input motor_phase, output ready);
endinterface

interface dss_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/dss_in_reg.sv
// ----------------------------------------------------------------------------
// dss_in_reg
// Input register stage: holds one accepted item until the update takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dss_in_reg
  import dss_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire item_t in_item,
  output logic       in_ready,
  input  wire logic  out_free,
  output stage_ctl_t ctl,
  output item_t      item
);

  logic valid;

  assign ctl.valid   = valid;
  assign ctl.advance = valid && out_free;
  assign in_ready    = !valid || ctl.advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

// File: design/dss_step.sv
// ----------------------------------------------------------------------------
// dss_step
// Head, stepper and spindle state with the single-pass update for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module dss_step
  import dss_pkg::*;
#(
  parameter int MAX_TRACK    = 42,
  parameter int CHANGE_TICKS = 15625
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire item_t            item,
  input  wire logic [TC_W-1:0]  track_count,
  output result_t               result
);

  localparam int TRACK_W = $clog2(MAX_TRACK + 1);
  localparam int CMP_W   = (TRACK_W > TC_W) ? TRACK_W : TC_W;
  localparam logic [TRACK_W-1:0] TRACK_MAX = TRACK_W'(MAX_TRACK);
  localparam logic [TRACK_W-1:0] TRACK_INS =
    TRACK_W'((INSERT_TRACK > MAX_TRACK) ? MAX_TRACK : INSERT_TRACK);
  localparam logic [CD_W-1:0] CD_INIT = CD_W'(CHANGE_TICKS);

  logic [FRAC_W-1:0]  frac;
  dir_t               dir;
  logic [1:0]         phase;
  logic [SPIN_W-1:0]  spin;
  logic [CD_W-1:0]    cd;
  logic [TRACK_W-1:0] track;
  logic               sense;

  logic [FRAC_W-1:0]  frac_next;
  dir_t               dir_next;
  logic [1:0]         phase_next;
  logic [SPIN_W-1:0]  spin_next;
  logic [CD_W-1:0]    cd_next;
  logic [TRACK_W-1:0] track_next;
  logic               sense_next;
  logic               ready_next;

  logic [FRAC_W-1:0]  frac_mv;
  logic [FRAC_W-1:0]  frac_xor;
  logic [1:0]         phase_mv;
  logic [1:0]         diff;
  logic [CD_W-1:0]    cd_dec;
  logic [SPIN_W-1:0]  spin_up;
  logic [CMP_W-1:0]   track_cmp;
  logic [CMP_W-1:0]   count_cmp;

  always_comb begin
    frac_next  = frac;
    dir_next   = dir;
    phase_next = phase;
    spin_next  = spin;
    cd_next    = cd;
    track_next = track;
    sense_next = sense;
    ready_next = 1'b0;

    // 128 per tick in the current direction
    frac_mv  = frac + {{(FRAC_W-9){dir[1]}}, dir, 7'b0};
    frac_xor = frac_mv ^ frac;
    phase_mv = phase;
    if (frac_xor[15:14] == 2'b01) begin
      phase_mv = (dir == DIR_UP) ? phase + 2'd1 : phase - 2'd1;
    end
    diff    = item.phase_cmd - phase_mv;
    cd_dec  = cd - CD_W'(1);
    spin_up = spin + SPIN_STEP;
    track_cmp = '0;
    count_cmp = CMP_W'(track_count);

    if (item.op == OP_INSERT) begin
      spin_next  = '0;
      cd_next    = CD_INIT;
      phase_next = 2'd0;
      track_next = TRACK_INS;
      frac_next  = '0;
      sense_next = item.write_protect;
    end else begin
      phase_next = phase_mv;
      if (diff == 2'd1) begin
        dir_next = DIR_UP;
      end else if (diff == 2'd3) begin
        dir_next = DIR_DOWN;
      end else if (!frac_mv[14]) begin
        // lower half of a track step: back out, or stop when on the track
        dir_next = (frac_mv[14:0] == '0) ? DIR_NONE : DIR_DOWN;
      end else begin
        dir_next = DIR_UP;
      end

      frac_next = frac_mv;
      if (frac_mv == FRAC_POS_LIMIT) begin
        frac_next  = '0;
        track_next = (track == TRACK_MAX) ? track : track + TRACK_W'(1);
      end else if (frac_mv == FRAC_NEG_LIMIT) begin
        frac_next  = '0;
        track_next = (track == '0) ? track : track - TRACK_W'(1);
      end

      if (cd != '0) begin
        cd_next = cd_dec;
        if (cd_dec == '0) begin
          sense_next = !item.write_protect;
          spin_next  = '0;
        end
      end else begin
        if (item.motor_on) begin
          spin_next = (spin_up > SPIN_FULL) ? SPIN_FULL : spin_up;
        end else begin
          spin_next = (spin < SPIN_STEP) ? '0 : spin - SPIN_STEP;
        end
        track_cmp  = CMP_W'(track_next);
        ready_next = (frac_next == '0) && (spin_next == SPIN_FULL) &&
                     (track_cmp != '0) && (track_cmp <= count_cmp);
      end
    end
  end

  assign result.head_ready    = ready_next;
  assign result.track_number  = TRK_OUT_W'(track_next);
  assign result.protect_sense = sense_next;
  assign result.motor_phase   = phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      frac  <= '0;
      dir   <= DIR_NONE;
      phase <= 2'd0;
      spin  <= '0;
      cd    <= CD_INIT;
      track <= TRACK_INS;
      sense <= 1'b0;
    end else if (advance) begin
      frac  <= frac_next;
      dir   <= dir_next;
      phase <= phase_next;
      spin  <= spin_next;
      cd    <= cd_next;
      track <= track_next;
      sense <= sense_next;
    end
  end

endmodule

`default_nettype wire

// File: design/dss_out_reg.sv
// ----------------------------------------------------------------------------
// dss_out_reg
// Result register: holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dss_out_reg
  import dss_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire stage_ctl_t ctl,
  input  wire result_t    in_result,
  output logic            out_free,
  output logic            out_valid,
  input  wire logic       out_ready,
  output result_t         out_result
);

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      out_result <= in_result;
    end
  end

endmodule

`default_nettype wire

// File: design/drive_stepper_spindle_model.sv
// ----------------------------------------------------------------------------
// drive_stepper_spindle_model
// Floppy head stepper and spindle model, one state update per tick item.
//
//   channel  dir  handshake        payload
//   cmd      in   valid / ready    op, phase_cmd, motor_on, write_protect
//   status   out  valid / ready    head_ready, track_number, protect_sense,
//                                  motor_phase
//   cfg      in   valid / ready    data = track_count
//
// An accepted cmd item passes the input register and then the result
// register before status goes valid; one item per cycle is taken and
// returned when status is not stalled. The state update sits between the
// input register and the result register. Reset clears both stages and
// sets the head to track 18 with the change countdown loaded.
// A stalled status holds its item; cmd keeps accepting until both stages
// are full. cfg is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module drive_stepper_spindle_model
  import dss_pkg::*;
#(
  parameter int MAX_TRACK    = 42,
  parameter int CHANGE_TICKS = 15625
) (
  input  wire logic clk,
  input  wire logic rst,
  dss_item_if.sink     cmd,
  dss_result_if.source status,
  dss_cfg_if.sink      cfg
);

  logic [TC_W-1:0] track_count;
  item_t           in_item;
  item_t           item;
  stage_ctl_t      ctl;
  logic            out_free;
  result_t         step_result;
  result_t         out_result;
  logic            in_ready;
  logic            out_valid;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      track_count <= TRACK_COUNT_RST;
    end else if (cfg.valid) begin
      track_count <= cfg.data;
    end
  end

  assign in_item.op            = cmd.op;
  assign in_item.phase_cmd     = cmd.phase_cmd;
  assign in_item.motor_on      = cmd.motor_on;
  assign in_item.write_protect = cmd.write_protect;
  assign cmd.ready             = in_ready;

  dss_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_item  (in_item),
    .in_ready (in_ready),
    .out_free (out_free),
    .ctl      (ctl),
    .item     (item)
  );

  dss_step #(
    .MAX_TRACK    (MAX_TRACK),
    .CHANGE_TICKS (CHANGE_TICKS)
  ) u_step (
    .clk         (clk),
    .rst         (rst),
    .advance     (ctl.advance),
    .item        (item),
    .track_count (track_count),
    .result      (step_result)
  );

  dss_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .in_result  (step_result),
    .out_free   (out_free),
    .out_valid  (out_valid),
    .out_ready  (status.ready),
    .out_result (out_result)
  );

  assign status.valid         = out_valid;
  assign status.head_ready    = out_result.head_ready;
  assign status.track_number  = out_result.track_number;
  assign status.protect_sense = out_result.protect_sense;
  assign status.motor_phase   = out_result.motor_phase;

endmodule

`default_nettype wire

// File: design/dss_checker.sv
// ----------------------------------------------------------------------------
// dss_checker
// Port-level checks on the status channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dss_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       st_valid,
  input wire logic       st_ready,
  input wire logic       st_head_ready,
  input wire logic [5:0] st_track_number,
  input wire logic       st_protect_sense,
  input wire logic [1:0] st_motor_phase
);

  // a stalled result item stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    st_valid && !st_ready |=> st_valid)
    else $error("status item dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    st_valid && !st_ready |=> $stable(st_head_ready) && $stable(st_track_number)
      && $stable(st_protect_sense) && $stable(st_motor_phase))
    else $error("status payload changed while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !st_valid)
    else $error("status valid right after reset");

  // a ready head never sits on track zero
  a_ready_track: assert property (@(posedge clk) disable iff (rst)
    st_valid && st_head_ready |-> st_track_number != 6'd0)
    else $error("head ready reported on track zero");

endmodule

bind drive_stepper_spindle_model dss_checker u_dss_checker (
  .clk              (clk),
  .rst              (rst),
  .st_valid         (status.valid),
  .st_ready         (status.ready),
  .st_head_ready    (status.head_ready),
  .st_track_number  (status.track_number),
  .st_protect_sense (status.protect_sense),
  .st_motor_phase   (status.motor_phase)
);

`default_nettype wire
